// File: hdl/nnfs_pkg.sv
package nnfs_pkg;

    localparam int SRC_DIM_MAX = 128;
    localparam int DST_DIM_MAX = 1024;

    localparam int SDIM_W      = 8;
    localparam int TDIM_W      = 11;
    localparam int COORD_W     = 10;
    localparam int PIX_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int FIT_W       = 2;

    localparam int SRC_IDX_W   = $clog2(SRC_DIM_MAX);
    localparam int ADDR_W      = 2 * SRC_IDX_W;
    localparam int STORE_DEPTH = SRC_DIM_MAX * SRC_DIM_MAX;

    // Scaled spans reach source size times target size, positions half of that.
    localparam int PROD_W      = SDIM_W + TDIM_W;
    localparam int SPAN_W      = PROD_W - 1;
    localparam int POS_W       = SPAN_W - 1;
    localparam int NUM_W       = POS_W + SDIM_W;
    localparam int RECIP_SHIFT = NUM_W - 1;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int QE_W        = NUM_W + RECIP_W - RECIP_SHIFT;
    localparam int DIV_W       = RECIP_W;
    localparam int CNT_W       = $clog2(DIV_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W = 3'd0,
        CFG_SRC_H = 3'd1,
        CFG_TGT_W = 3'd2,
        CFG_TGT_H = 3'd3,
        CFG_FIT   = 3'd4
    } t_cfg_idx;

    localparam logic [FIT_W-1:0] FIT_FILL    = 2'd0;
    localparam logic [FIT_W-1:0] FIT_CONTAIN = 2'd1;
    localparam logic [FIT_W-1:0] FIT_COVER   = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef enum logic [6:0] {
        ST_DIM  = 7'b0000001,
        ST_DIMW = 7'b0000010,
        ST_RX   = 7'b0000100,
        ST_RXW  = 7'b0001000,
        ST_RY   = 7'b0010000,
        ST_RYW  = 7'b0100000,
        ST_RUN  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic              fetch;
        logic              bad;
        logic              blank;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } t_meta;

endpackage

// File: hdl/nearest_neighbor_fit_scaler.sv
// Nearest-neighbour RGBA scaler with fill, contain and cover fit modes.
// An accepted request passes through the item pipeline registers to the outputs.
// Throughput: one request per cycle, in any mix of loads and fetches, while the output is taken and no setup runs.
// Reset (synchronous, active low) restores the register defaults and runs the
// geometry setup; the same setup follows every configuration write,
// and input requests are held off until it ends. The source store is not cleared.
module nearest_neighbor_fit_scaler
    import nnfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [COORD_W-1:0]    i_coord_x,
    input  logic [COORD_W-1:0]    i_coord_y,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_blank,
    output logic                  o_bad_coord,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Raw configuration registers.
    logic [SDIM_W-1:0] r_src_w, r_src_h;
    logic [TDIM_W-1:0] r_tgt_w, r_tgt_h;
    logic [FIT_W-1:0]  r_fit;

    // Clamped dimensions: zero reads as one, anything above the maximum as the maximum.
    logic [SDIM_W-1:0] c_sw, c_sh;
    logic [TDIM_W-1:0] c_tw, c_th;

    always_comb begin
        c_sw = (r_src_w == '0) ? SDIM_W'(1) :
               (32'(r_src_w) > SRC_DIM_MAX) ? SDIM_W'(SRC_DIM_MAX) : r_src_w;
        c_sh = (r_src_h == '0) ? SDIM_W'(1) :
               (32'(r_src_h) > SRC_DIM_MAX) ? SDIM_W'(SRC_DIM_MAX) : r_src_h;
        c_tw = (r_tgt_w == '0) ? TDIM_W'(1) :
               (32'(r_tgt_w) > DST_DIM_MAX) ? TDIM_W'(DST_DIM_MAX) : r_tgt_w;
        c_th = (r_tgt_h == '0) ? TDIM_W'(1) :
               (32'(r_tgt_h) > DST_DIM_MAX) ? TDIM_W'(DST_DIM_MAX) : r_tgt_h;
    end

    // ------------------------------------------------------------------
    // Geometry setup. One serial restoring divider is shared by three
    // divisions: the scaled dimension for contain and cover, then the
    // reciprocals of the horizontal and vertical spans that the item
    // pipeline multiplies by in place of a divide.
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [DIV_W-1:0]  r_quo;
    logic [SPAN_W-1:0] r_rem;
    logic [SPAN_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;

    logic [SPAN_W:0]   c_rem_sh;
    logic              c_ge;
    logic [SPAN_W:0]   c_rem_sub;

    always_comb begin
        c_rem_sh  = {r_rem, r_quo[DIV_W-1]};
        c_ge      = c_rem_sh >= {1'b0, r_dvs};
        c_rem_sub = c_rem_sh - {1'b0, r_dvs};
    end

    // Aspect comparison and the dimension division's operands.
    logic [PROD_W-1:0] c_lhs, c_rhs;
    logic              c_wide;
    logic [DIV_W-1:0]  c_dim_num;
    logic [SPAN_W-1:0] c_dim_den;

    always_comb begin
        c_lhs  = PROD_W'(c_sw) * PROD_W'(c_th);
        c_rhs  = PROD_W'(c_sh) * PROD_W'(c_tw);
        c_wide = c_lhs >= c_rhs;
        if (r_fit == FIT_COVER) begin
            // Ceiling division: add the divisor less one before dividing.
            c_dim_den = c_wide ? SPAN_W'(c_sh) : SPAN_W'(c_sw);
            c_dim_num = DIV_W'(c_wide ? c_lhs : c_rhs) + DIV_W'(c_dim_den) - DIV_W'(1);
        end else begin
            c_dim_den = c_wide ? SPAN_W'(c_sw) : SPAN_W'(c_sh);
            c_dim_num = DIV_W'(c_wide ? c_rhs : c_lhs);
        end
    end

    // Placement derived from the scaled dimension once it is known.
    logic [SPAN_W-1:0] c_dim;
    logic [SPAN_W-1:0] c_spx, c_spy;
    logic [POS_W-1:0]  c_addx, c_addy;
    logic [TDIM_W-1:0] c_ox, c_oy;
    logic [TDIM_W:0]   c_hix, c_hiy;
    logic              c_blk;
    logic [SPAN_W-1:0] c_dx, c_dy;

    always_comb begin
        c_dim  = (r_quo == '0) ? SPAN_W'(1) : r_quo[SPAN_W-1:0];
        c_spx  = SPAN_W'(c_tw);
        c_spy  = SPAN_W'(c_th);
        c_addx = '0;
        c_addy = '0;
        c_ox   = '0;
        c_oy   = '0;
        c_hix  = '0;
        c_hiy  = '0;
        c_blk  = 1'b0;
        c_dx   = '0;
        c_dy   = '0;
        if (r_fit == FIT_CONTAIN) begin
            c_spx  = c_wide ? SPAN_W'(c_tw) : c_dim;
            c_spy  = c_wide ? c_dim : SPAN_W'(c_th);
            // The floored span never exceeds the target, so the offsets fit.
            c_dx   = SPAN_W'(c_tw) - c_spx;
            c_dy   = SPAN_W'(c_th) - c_spy;
            c_ox   = TDIM_W'(c_dx >> 1);
            c_oy   = TDIM_W'(c_dy >> 1);
            c_hix  = (TDIM_W + 1)'(c_ox) + (TDIM_W + 1)'(c_spx);
            c_hiy  = (TDIM_W + 1)'(c_oy) + (TDIM_W + 1)'(c_spy);
            c_blk  = 1'b1;
        end else if (r_fit == FIT_COVER) begin
            c_spx  = c_wide ? c_dim : SPAN_W'(c_tw);
            c_spy  = c_wide ? SPAN_W'(c_th) : c_dim;
            c_dx   = c_spx - SPAN_W'(c_tw);
            c_dy   = c_spy - SPAN_W'(c_th);
            c_addx = (c_spx > SPAN_W'(c_tw)) ? POS_W'(c_dx >> 1) : '0;
            c_addy = (c_spy > SPAN_W'(c_th)) ? POS_W'(c_dy >> 1) : '0;
        end
    end

    // Stored geometry used by every fetch.
    logic [SPAN_W-1:0]  r_spx, r_spy;
    logic [POS_W-1:0]   r_addx, r_addy;
    logic [TDIM_W-1:0]  r_ox, r_oy;
    logic [TDIM_W:0]    r_hix, r_hiy;
    logic               r_blk;
    logic [RECIP_W-1:0] r_mx, r_my;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_DIM:  n_state = ST_DIMW;
            ST_DIMW: if (r_cnt == '0) n_state = ST_RX;
            ST_RX:   n_state = ST_RXW;
            ST_RXW:  if (r_cnt == '0) n_state = ST_RY;
            ST_RY:   n_state = ST_RYW;
            ST_RYW:  if (r_cnt == '0) n_state = ST_RUN;
            ST_RUN:  n_state = ST_RUN;
            default: n_state = ST_DIM;
        endcase
        // Any register write makes the stored geometry stale.
        if (i_cfg_valid) begin
            n_state = ST_DIM;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DIM;
            r_src_w <= SDIM_W'(1);
            r_src_h <= SDIM_W'(1);
            r_tgt_w <= TDIM_W'(1);
            r_tgt_h <= TDIM_W'(1);
            r_fit   <= FIT_FILL;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SRC_W: r_src_w <= i_cfg_data[SDIM_W-1:0];
                    CFG_SRC_H: r_src_h <= i_cfg_data[SDIM_W-1:0];
                    CFG_TGT_W: r_tgt_w <= i_cfg_data[TDIM_W-1:0];
                    CFG_TGT_H: r_tgt_h <= i_cfg_data[TDIM_W-1:0];
                    CFG_FIT:   r_fit   <= i_cfg_data[FIT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    // Divider and geometry registers hold payload only.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_DIM: begin
                r_quo <= c_dim_num;
                r_dvs <= c_dim_den;
                r_rem <= '0;
                r_cnt <= CNT_W'(DIV_W);
            end
            ST_RX, ST_RY: begin
                r_quo <= DIV_W'(1) << RECIP_SHIFT;
                r_dvs <= (r_state == ST_RX) ? r_spx : r_spy;
                r_rem <= '0;
                r_cnt <= CNT_W'(DIV_W);
            end
            ST_DIMW, ST_RXW, ST_RYW: begin
                if (r_cnt != '0) begin
                    r_quo <= {r_quo[DIV_W-2:0], c_ge};
                    r_rem <= c_ge ? c_rem_sub[SPAN_W-1:0] : c_rem_sh[SPAN_W-1:0];
                    r_cnt <= r_cnt - CNT_W'(1);
                end else if (r_state == ST_DIMW) begin
                    r_spx  <= c_spx;
                    r_spy  <= c_spy;
                    r_addx <= c_addx;
                    r_addy <= c_addy;
                    r_ox   <= c_ox;
                    r_oy   <= c_oy;
                    r_hix  <= c_hix;
                    r_hiy  <= c_hiy;
                    r_blk  <= c_blk;
                end else if (r_state == ST_RXW) begin
                    r_mx <= r_quo[RECIP_W-1:0];
                end else begin
                    r_my <= r_quo[RECIP_W-1:0];
                end
            end
            ST_RUN: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Item pipeline, six stages:
    //   1 range checks, contain border, axis positions
    //   2 position times source length
    //   3 multiply by the span reciprocal, giving a quotient low by at most one
    //   4 quotient estimate times span
    //   5 remainder correction and clamp to the last row and column
    //   6 store access; this stage is the output register
    // The whole pipeline moves together whenever the output is free or taken.
    // ------------------------------------------------------------------
    logic c_adv;
    assign c_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = c_adv && (r_state == ST_RUN);

    logic [5:0] r_v;
    t_meta      r_meta [6];

    logic c_fetch, c_bad, c_blank;
    logic [POS_W-1:0] c_posx, c_posy;

    always_comb begin
        c_fetch = (i_func == FUNC_FETCH);
        if (c_fetch) begin
            c_bad = (TDIM_W'(i_coord_x) >= c_tw) || (TDIM_W'(i_coord_y) >= c_th);
        end else begin
            c_bad = ((COORD_W + 1)'(i_coord_x) >= (COORD_W + 1)'(c_sw)) ||
                    ((COORD_W + 1)'(i_coord_y) >= (COORD_W + 1)'(c_sh));
        end
        c_blank = c_fetch && !c_bad && r_blk &&
                  ((TDIM_W'(i_coord_x) < r_ox) || ((TDIM_W + 1)'(i_coord_x) >= r_hix) ||
                   (TDIM_W'(i_coord_y) < r_oy) || ((TDIM_W + 1)'(i_coord_y) >= r_hiy));
        // On the border or out of range the position is meaningless and unused.
        c_posx  = POS_W'(i_coord_x) + r_addx - POS_W'(r_ox);
        c_posy  = POS_W'(i_coord_y) + r_addy - POS_W'(r_oy);
    end

    logic [POS_W-1:0]  r_pos [2];
    logic [NUM_W-1:0]  r_n2  [2];
    logic [NUM_W-1:0]  r_n3  [2];
    logic [QE_W-1:0]   r_qe3 [2];
    logic [NUM_W-1:0]  r_n4  [2];
    logic [QE_W-1:0]   r_qe4 [2];
    logic [QE_W-1:0]   r_qd4 [2];
    logic [SRC_IDX_W-1:0] r_q5 [2];

    logic [SDIM_W-1:0]          c_src [2];
    logic [SPAN_W-1:0]          c_sp  [2];
    logic [RECIP_W-1:0]         c_m   [2];
    logic [NUM_W+RECIP_W-1:0]   c_p3  [2];
    logic [QE_W+SPAN_W-1:0]     c_p4  [2];
    logic [QE_W-1:0]            c_r5  [2];
    logic [QE_W-1:0]            c_q5  [2];
    logic [SRC_IDX_W-1:0]       c_qc5 [2];

    always_comb begin
        c_src[0] = c_sw;
        c_src[1] = c_sh;
        c_sp[0]  = r_spx;
        c_sp[1]  = r_spy;
        c_m[0]   = r_mx;
        c_m[1]   = r_my;
        for (int a = 0; a < 2; a++) begin
            c_p3[a]  = (NUM_W + RECIP_W)'(r_n2[a]) * (NUM_W + RECIP_W)'(c_m[a]);
            c_p4[a]  = (QE_W + SPAN_W)'(r_qe3[a]) * (QE_W + SPAN_W)'(c_sp[a]);
            c_r5[a]  = QE_W'(r_n4[a]) - r_qd4[a];
            c_q5[a]  = r_qe4[a] + ((c_r5[a] >= QE_W'(c_sp[a])) ? QE_W'(1) : QE_W'(0));
            c_qc5[a] = (c_q5[a] >= QE_W'(c_src[a])) ?
                       SRC_IDX_W'(c_src[a] - SDIM_W'(1)) : SRC_IDX_W'(c_q5[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (c_adv) begin
            r_v <= {r_v[4:0], i_in_valid && o_in_ready};
        end
    end

    // Source store: one write and one read per cycle while the pipeline advances, read data registered.
    logic [PIX_W-1:0] r_store [STORE_DEPTH];
    logic [PIX_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_meta[0].fetch <= c_fetch;
            r_meta[0].bad   <= c_bad;
            r_meta[0].blank <= c_blank;
            r_meta[0].addr  <= {i_coord_y[SRC_IDX_W-1:0], i_coord_x[SRC_IDX_W-1:0]};
            r_meta[0].pix   <= i_pixel_in;
            r_pos[0] <= c_posx;
            r_pos[1] <= c_posy;
            for (int s = 1; s < 6; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
            for (int a = 0; a < 2; a++) begin
                r_n2[a]  <= NUM_W'(r_pos[a]) * NUM_W'(c_src[a]);
                r_n3[a]  <= r_n2[a];
                r_qe3[a] <= c_p3[a][NUM_W+RECIP_W-1:RECIP_SHIFT];
                r_n4[a]  <= r_n3[a];
                r_qe4[a] <= r_qe3[a];
                r_qd4[a] <= c_p4[a][QE_W-1:0];
                r_q5[a]  <= c_qc5[a];
            end
            if (r_v[4] && r_meta[4].fetch == FUNC_LOAD && !r_meta[4].bad) begin
                r_store[r_meta[4].addr] <= r_meta[4].pix;
            end
            r_rd <= r_store[{r_q5[1], r_q5[0]}];
        end
    end

    assign o_out_valid = r_v[5];
    assign o_blank     = r_meta[5].blank;
    assign o_bad_coord = r_meta[5].bad;
    assign o_pixel_out = (r_meta[5].fetch && !r_meta[5].bad && !r_meta[5].blank) ?
                         r_rd : '0;

endmodule

// File: hdl/nnfs_checker.sv
module nnfs_checker
    import nnfs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [PIX_W-1:0]      o_pixel_out,
    input logic                  o_blank,
    input logic                  o_bad_coord
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_out) &&
        $stable(o_blank) && $stable(o_bad_coord))
        else $error("stalled result changed");

    // A border result carries no pixel and no range error.
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_blank |-> o_pixel_out == '0 && !o_bad_coord)
        else $error("blank result carries data");

    // An out-of-range request returns zero.
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_coord |-> o_pixel_out == '0)
        else $error("bad request carries data");

    // Reset empties the pipeline.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

    // No request is taken directly after a reset cycle; the geometry setup holds it off.
    a_setup: assert property (@(posedge i_clk)
        !i_rst_n |=> !(i_in_valid && o_in_ready))
        else $error("request taken during setup");

endmodule

bind nearest_neighbor_fit_scaler nnfs_checker u_nnfs_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import nnfs_pkg::*;

    // Fit code 3 is unused by the block and must behave as fill.
    localparam logic [FIT_W-1:0] FIT_SPARE = 2'd3;

    // One request towards the scaler: a load of a source pixel or a fetch of a
    // destination pixel.
    typedef struct {
        logic               fetch;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
    } t_scale_req;

    // One answer from the scaler.
    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             blank;
        logic             bad;
    } t_scale_ans;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_func;
    logic [COORD_W-1:0]    i_coord_x;
    logic [COORD_W-1:0]    i_coord_y;
    logic [PIX_W-1:0]      i_pixel_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_blank;
    logic                  o_bad_coord;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    nearest_neighbor_fit_scaler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .o_blank     (o_blank),
        .o_bad_coord (o_bad_coord),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Requests waiting to be driven, and answers still owed by the scaler.
    t_scale_req scale_requests[$];
    t_scale_ans expected_pixels[$];

    // The testbench's own copy of the registers and of the source image.
    logic [SDIM_W-1:0] reg_src_w;
    logic [SDIM_W-1:0] reg_src_h;
    logic [TDIM_W-1:0] reg_tgt_w;
    logic [TDIM_W-1:0] reg_tgt_h;
    logic [FIT_W-1:0]  reg_fit;
    logic [PIX_W-1:0]  src_image [STORE_DEPTH];

    // Entries the stimulus has already loaded; a fetch is only ever issued
    // once the entry it maps onto is known to hold a pixel.
    bit loaded [STORE_DEPTH];

    int  err_count;
    int  n_loads;
    int  n_fetches;
    int  n_blanks;
    int  n_bad;
    int  n_cfg;
    bit  no_idle;
    bit  in_fire;
    int  in_idle;
    int  out_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A width or height of zero counts as one, and anything above the
    // maximum counts as the maximum.
    function automatic longint eff_dim(input longint v, input longint maxv);
        if (v == 0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    // Nearest source index on one axis, clamped to the last row or column.
    function automatic longint nearest_src(input longint pos, input longint len,
                                           input longint span);
        longint q;
        q = (pos * len) / span;
        if (q >= len) begin
            q = len - 1;
        end
        return q;
    endfunction

    // Works out where a destination pixel comes from under the present
    // registers: out of range, on the contain border, or a store address.
    function automatic void map_dest(input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     output bit bad, output bit blank,
                                     output int unsigned addr);
        longint sw, sh, tw, th, cw, ch, ox, oy, sx, sy;
        sw = eff_dim(reg_src_w, SRC_DIM_MAX);
        sh = eff_dim(reg_src_h, SRC_DIM_MAX);
        tw = eff_dim(reg_tgt_w, DST_DIM_MAX);
        th = eff_dim(reg_tgt_h, DST_DIM_MAX);
        bad = 0;
        blank = 0;
        addr = 0;
        if (x >= tw || y >= th) begin
            bad = 1;
            return;
        end
        if (reg_fit == FIT_CONTAIN) begin
            // Fit the whole image inside the target, then centre it.
            if (sw * th >= sh * tw) begin
                cw = tw;
                ch = (sh * tw) / sw;
            end else begin
                ch = th;
                cw = (sw * th) / sh;
            end
            if (cw == 0) cw = 1;
            if (ch == 0) ch = 1;
            ox = (tw - cw) / 2;
            oy = (th - ch) / 2;
            if (x < ox || x >= ox + cw || y < oy || y >= oy + ch) begin
                blank = 1;
                return;
            end
            sx = nearest_src(x - ox, sw, cw);
            sy = nearest_src(y - oy, sh, ch);
        end else if (reg_fit == FIT_COVER) begin
            // Scale up until the target is covered, rounding up, and crop
            // the overhang from both sides, any odd pixel from the far side.
            if (sw * th >= sh * tw) begin
                ch = th;
                cw = (sw * th + sh - 1) / sh;
            end else begin
                cw = tw;
                ch = (sh * tw + sw - 1) / sw;
            end
            if (cw == 0) cw = 1;
            if (ch == 0) ch = 1;
            ox = (cw > tw) ? (cw - tw) / 2 : 0;
            oy = (ch > th) ? (ch - th) / 2 : 0;
            sx = nearest_src(x + ox, sw, cw);
            sy = nearest_src(y + oy, sh, ch);
        end else begin
            // Fill, and the spare code which behaves the same way.
            sx = nearest_src(x, sw, tw);
            sy = nearest_src(y, sh, th);
        end
        addr = int'(sy * SRC_DIM_MAX + sx);
    endfunction

    function automatic bit load_in_range(input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y);
        return x < eff_dim(reg_src_w, SRC_DIM_MAX) && y < eff_dim(reg_src_h, SRC_DIM_MAX);
    endfunction

    // Queues a load, noting the entry as filled if the block will take it.
    task automatic queue_load(input int x, input int y, input logic [PIX_W-1:0] pix);
        t_scale_req r;
        r.fetch = FUNC_LOAD;
        r.x = COORD_W'(x);
        r.y = COORD_W'(y);
        r.pix = pix;
        if (load_in_range(r.x, r.y)) begin
            loaded[r.y * SRC_DIM_MAX + r.x] = 1;
        end
        scale_requests.push_back(r);
    endtask

    // Queues a fetch; if it would land on an entry not yet loaded, a load of
    // that entry goes in first. The payload field carries noise, which the
    // block must ignore for fetches.
    task automatic queue_fetch(input int x, input int y);
        t_scale_req  r;
        bit          bad;
        bit          blank;
        int unsigned addr;
        r.fetch = FUNC_FETCH;
        r.x = COORD_W'(x);
        r.y = COORD_W'(y);
        r.pix = $urandom;
        map_dest(r.x, r.y, bad, blank, addr);
        if (!bad && !blank && !loaded[addr]) begin
            queue_load(addr % SRC_DIM_MAX, addr / SRC_DIM_MAX, $urandom);
        end
        scale_requests.push_back(r);
    endtask

    // Random traffic under the present registers: mostly in-range loads and
    // fetches, with some requests anywhere in the full coordinate space.
    task automatic queue_random(input int count);
        int sw, sh, tw, th, pick;
        sw = int'(eff_dim(reg_src_w, SRC_DIM_MAX));
        sh = int'(eff_dim(reg_src_h, SRC_DIM_MAX));
        tw = int'(eff_dim(reg_tgt_w, DST_DIM_MAX));
        th = int'(eff_dim(reg_tgt_h, DST_DIM_MAX));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                queue_load($urandom_range(0, sw - 1), $urandom_range(0, sh - 1), $urandom);
            end else if (pick == 3) begin
                queue_load($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
            end else if (pick == 4) begin
                queue_fetch($urandom_range(0, 1023), $urandom_range(0, 1023));
            end else begin
                queue_fetch($urandom_range(0, tw - 1), $urandom_range(0, th - 1));
            end
        end
    endtask

    // Waits until every request has gone in and every answer has come back,
    // then lets the pipeline settle before it returns.
    task automatic drain();
        while (scale_requests.size() != 0 || expected_pixels.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reprograms the whole geometry; only called with the block idle.
    task automatic set_geometry(input int sw, input int sh, input int tw, input int th,
                                input logic [FIT_W-1:0] fit);
        drain();
        write_reg(CFG_SRC_W, sw);
        write_reg(CFG_SRC_H, sh);
        write_reg(CFG_TGT_W, tw);
        write_reg(CFG_TGT_H, th);
        write_reg(CFG_FIT, fit);
    endtask

    // Register writes are mirrored into the predictor when the block takes them.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            n_cfg <= n_cfg + 1;
            case (i_cfg_index)
                CFG_SRC_W: reg_src_w <= i_cfg_data[SDIM_W-1:0];
                CFG_SRC_H: reg_src_h <= i_cfg_data[SDIM_W-1:0];
                CFG_TGT_W: reg_tgt_w <= i_cfg_data;
                CFG_TGT_H: reg_tgt_h <= i_cfg_data;
                CFG_FIT:   reg_fit   <= i_cfg_data[FIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request side, sampling: each accepted request is predicted at once, in
    // acceptance order, so loads and fetches see the image exactly as the
    // block does.
    always @(posedge i_clk) begin
        t_scale_ans  a;
        bit          bad;
        bit          blank;
        int unsigned addr;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            a.pix = '0;
            a.blank = 1'b0;
            a.bad = 1'b0;
            if (i_func == FUNC_LOAD) begin
                n_loads <= n_loads + 1;
                if (load_in_range(i_coord_x, i_coord_y)) begin
                    src_image[i_coord_y * SRC_DIM_MAX + i_coord_x] = i_pixel_in;
                end else begin
                    a.bad = 1'b1;
                end
            end else begin
                n_fetches <= n_fetches + 1;
                map_dest(i_coord_x, i_coord_y, bad, blank, addr);
                a.bad = bad;
                a.blank = blank;
                if (!bad && !blank) begin
                    a.pix = src_image[addr];
                end
            end
            if (a.blank) n_blanks <= n_blanks + 1;
            if (a.bad) n_bad <= n_bad + 1;
            expected_pixels.push_back(a);
        end
    end

    // Request side, driving: a new request is only put up once the previous
    // one was taken, with random idle bursts in between.
    always @(negedge i_clk) begin
        t_scale_req r;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (in_idle > 0) begin
                in_idle <= in_idle - 1;
                i_in_valid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                in_idle <= $urandom_range(0, 12);
                i_in_valid <= 1'b0;
            end else if (scale_requests.size() != 0) begin
                r = scale_requests.pop_front();
                i_in_valid <= 1'b1;
                i_func     <= r.fetch;
                i_coord_x  <= r.x;
                i_coord_y  <= r.y;
                i_pixel_in <= r.pix;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Answer side, back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_idle > 0) begin
                out_idle <= out_idle - 1;
                i_out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                out_idle <= $urandom_range(0, 12);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Answer side, checking against the oldest prediction.
    always @(posedge i_clk) begin
        t_scale_ans e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected answer: pixel %h blank %b bad %b",
                       o_pixel_out, o_blank, o_bad_coord);
                err_count++;
            end else begin
                e = expected_pixels.pop_front();
                if (o_pixel_out !== e.pix) begin
                    $error("pixel_out: expected %h, got %h", e.pix, o_pixel_out);
                    err_count++;
                end
                if (o_blank !== e.blank) begin
                    $error("blank: expected %b, got %b", e.blank, o_blank);
                    err_count++;
                end
                if (o_bad_coord !== e.bad) begin
                    $error("bad_coord: expected %b, got %b", e.bad, o_bad_coord);
                    err_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_LOAD;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_pixel_in  = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SRC_W;
        i_cfg_data  = '0;
        reg_src_w   = 1;
        reg_src_h   = 1;
        reg_tgt_w   = 1;
        reg_tgt_h   = 1;
        reg_fit     = FIT_FILL;
        err_count   = 0;
        n_loads     = 0;
        n_fetches   = 0;
        n_blanks    = 0;
        n_bad       = 0;
        n_cfg       = 0;
        no_idle     = 0;
        in_idle     = 0;
        out_idle    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry, one by one: a single all-ones pixel, loads and
        // fetches just outside and at the far corner of coordinate space.
        queue_load(0, 0, 32'hFFFF_FFFF);
        queue_load(1, 0, 32'h1234_5678);
        queue_load(1023, 1023, 32'hA5A5_5A5A);
        queue_fetch(0, 0);
        queue_fetch(1, 0);
        queue_fetch(0, 1023);
        queue_load(0, 0, 32'h0000_0000);
        queue_fetch(0, 0);

        // Contain on a wide target: the image is pillar-boxed, so the left
        // and right columns are border and the middle is picture.
        set_geometry(4, 3, 16, 9, FIT_CONTAIN);
        queue_fetch(0, 0);
        queue_fetch(8, 4);
        queue_fetch(15, 8);
        queue_fetch(16, 0);
        queue_random(30);

        // Cover on a tall target: the sides are cropped.
        set_geometry(4, 3, 9, 16, FIT_COVER);
        queue_fetch(0, 0);
        queue_fetch(8, 15);
        queue_random(30);

        // Largest sizes everywhere.
        set_geometry(SRC_DIM_MAX, SRC_DIM_MAX, DST_DIM_MAX, DST_DIM_MAX, FIT_FILL);
        queue_load(127, 127, 32'h8000_0001);
        queue_fetch(1023, 1023);
        queue_fetch(0, 0);
        queue_random(30);

        // Zero sizes count as one; the spare fit code behaves as fill.
        set_geometry(0, 0, 0, 0, FIT_SPARE);
        queue_load(0, 0, 32'h0F0F_F0F0);
        queue_fetch(0, 0);
        queue_fetch(0, 1);
        queue_random(20);

        // Oversized values clamp to the maxima; pillar-boxed contain.
        set_geometry(255, 7, 2047, 5, FIT_CONTAIN);
        queue_random(30);

        // A one-pixel-wide column stretched into a one-row target.
        set_geometry(1, SRC_DIM_MAX, DST_DIM_MAX, 1, FIT_COVER);
        queue_random(30);

        set_geometry(SRC_DIM_MAX, 1, 1, DST_DIM_MAX, FIT_CONTAIN);
        queue_random(30);

        // Random geometries, mostly small; the last runs without idling.
        for (int p = 0; p < 4; p++) begin
            set_geometry($urandom_range(1, 16), $urandom_range(1, 16),
                         $urandom_range(1, 64), $urandom_range(1, 64),
                         FIT_W'($urandom_range(0, 3)));
            if (p == 3) begin
                no_idle = 1;
            end
            queue_random(30);
        end
        drain();

        $display("tb: %0d loads and %0d fetches checked over %0d register writes",
                 n_loads, n_fetches, n_cfg);
        $display("tb: %0d border answers, %0d out-of-range answers", n_blanks, n_bad);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/nnfs_pkg.sv
hdl/nearest_neighbor_fit_scaler.sv
hdl/nnfs_checker.sv
tb/sv/tb.sv
